FILE: src/pca_pkg.sv
// Shared types and constants for the priority command arbiter.
`default_nettype none
package pca_pkg;

  localparam int NUM_SRC = 3;

  localparam int VEL_W  = 16;
  localparam int LIM_W  = 15;
  localparam int PRI_W  = 16;
  localparam int TMO_W  = 16;
  localparam int TIME_W = 48;
  localparam int IDX_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [IDX_W-1:0] NO_SRC = 2'd3;

  localparam logic MODE_CMD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIN_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRI0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRI1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRI2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TMO0      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TMO1      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TMO2      = 3'd7;

  // Reset values: 1.0 and 0.9 in Q4.12, priorities, 250 ms timeouts
  localparam logic [LIM_W-1:0] LIN_LIMIT_RST = 15'd4096;
  localparam logic [LIM_W-1:0] ANG_LIMIT_RST = 15'd3686;
  localparam logic signed [PRI_W-1:0] PRI0_RST = 16'sd100;
  localparam logic signed [PRI_W-1:0] PRI1_RST = 16'sd50;
  localparam logic signed [PRI_W-1:0] PRI2_RST = 16'sd10;
  localparam logic [TMO_W-1:0] TMO_RST = 16'd250;

  typedef struct packed {
    logic capture;  // register the accepted item
    logic store;    // apply a command item to the source table
    logic eval;     // register freshness and pairwise ranking
    logic load;     // write the selection into the output register
  } pca_cmd_t;

  typedef struct packed {
    logic is_tick;
  } pca_sts_t;

endpackage
`default_nettype wire

FILE: src/pca_ctrl.sv
// Controller state machine: sequences capture, store, evaluate and output load.
`default_nettype none
module pca_ctrl
  import pca_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire pca_sts_t sts,
  output pca_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STORE = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;
  localparam logic [1:0] ST_PICK  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_STORE;
        end
      end
      ST_STORE: begin
        if (sts.is_tick) begin
          cmd.eval  = 1'b1;
          state_nxt = ST_PICK;
        end else begin
          cmd.store = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_IDLE;
      end
      ST_PICK: begin
        // hold the selection until the output register is free
        if (out_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/pca_dp.sv
// Datapath: configuration, source table, freshness and ranking, output register.
`default_nettype none
module pca_dp
  import pca_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pca_cmd_t                 cmd,
  output pca_sts_t                      sts,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                     in_mode,
  input  wire logic [IDX_W-1:0]         in_source_index,
  input  wire logic signed [VEL_W-1:0]  in_linear_velocity_in,
  input  wire logic signed [VEL_W-1:0]  in_angular_velocity_in,
  input  wire logic                     in_not_finite,
  input  wire logic [TIME_W-1:0]        in_current_time,
  output logic signed [VEL_W-1:0]       out_linear_velocity_out,
  output logic signed [VEL_W-1:0]       out_angular_velocity_out,
  output logic [IDX_W-1:0]              out_selected_source,
  output logic                          out_source_changed
);

  // configuration
  logic [LIM_W-1:0]        lin_limit_r, ang_limit_r;
  logic signed [PRI_W-1:0] pri_r [NUM_SRC];
  logic [TMO_W-1:0]        tmo_r [NUM_SRC];

  // captured item
  logic                    mode_r;
  logic [IDX_W-1:0]        idx_r;
  logic signed [VEL_W-1:0] lin_r, ang_r;
  logic                    nf_r;
  logic [TIME_W-1:0]       now_r;

  // source table
  logic signed [VEL_W-1:0] st_lin_r [NUM_SRC];
  logic signed [VEL_W-1:0] st_ang_r [NUM_SRC];
  logic [TIME_W-1:0]       st_time_r [NUM_SRC];
  logic [NUM_SRC-1:0]      held_r;

  // evaluation
  logic [NUM_SRC-1:0] fresh_nxt, fresh_r;
  logic b01_nxt, b02_nxt, b12_nxt;
  logic b01_r, b02_r, b12_r;
  logic [NUM_SRC-1:0] win;
  logic [IDX_W-1:0]   sel_code;

  logic [IDX_W-1:0]        active_r;
  logic signed [VEL_W-1:0] out_lin_r, out_ang_r;
  logic [IDX_W-1:0]        out_sel_r;
  logic                    out_chg_r;

  logic signed [VEL_W-1:0] lin_clamped, ang_clamped;

  assign sts.is_tick = (mode_r == MODE_TICK);

  function automatic logic signed [VEL_W-1:0] clamp_mag(
    input logic signed [VEL_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [VEL_W:0] vx;
    logic signed [VEL_W:0] lp;
    logic signed [VEL_W:0] r;
    vx = {v[VEL_W-1], v};
    lp = $signed({2'b00, lim});
    if (vx > lp) begin
      r = lp;
    end else if (vx < -lp) begin
      r = -lp;
    end else begin
      r = vx;
    end
    return r[VEL_W-1:0];
  endfunction

  assign lin_clamped = clamp_mag(lin_r, lin_limit_r);
  assign ang_clamped = clamp_mag(ang_r, ang_limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_limit_r <= LIN_LIMIT_RST;
      ang_limit_r <= ANG_LIMIT_RST;
      pri_r[0]    <= PRI0_RST;
      pri_r[1]    <= PRI1_RST;
      pri_r[2]    <= PRI2_RST;
      tmo_r[0]    <= TMO_RST;
      tmo_r[1]    <= TMO_RST;
      tmo_r[2]    <= TMO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIN_LIMIT: lin_limit_r <= cfg_data[LIM_W-1:0];
        REG_ANG_LIMIT: ang_limit_r <= cfg_data[LIM_W-1:0];
        REG_PRI0:      pri_r[0]    <= $signed(cfg_data);
        REG_PRI1:      pri_r[1]    <= $signed(cfg_data);
        REG_PRI2:      pri_r[2]    <= $signed(cfg_data);
        REG_TMO0:      tmo_r[0]    <= cfg_data;
        REG_TMO1:      tmo_r[1]    <= cfg_data;
        REG_TMO2:      tmo_r[2]    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      idx_r  <= in_source_index;
      lin_r  <= in_linear_velocity_in;
      ang_r  <= in_angular_velocity_in;
      nf_r   <= in_not_finite;
      now_r  <= in_current_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.store && idx_r != NO_SRC) begin
      // a non-finite command drops the source
      held_r[idx_r] <= !nf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && idx_r != NO_SRC && !nf_r) begin
      st_lin_r[idx_r]  <= lin_clamped;
      st_ang_r[idx_r]  <= ang_clamped;
      st_time_r[idx_r] <= now_r;
    end
  end

  // age must lie in [0, timeout]
  always_comb begin
    for (int i = 0; i < NUM_SRC; i++) begin
      fresh_nxt[i] = held_r[i] && (now_r >= st_time_r[i]) &&
                     ((now_r - st_time_r[i]) <= {{(TIME_W-TMO_W){1'b0}}, tmo_r[i]});
    end
  end

  // lower index beats higher index unless strictly lower priority or older
  assign b01_nxt = (pri_r[0] > pri_r[1]) ||
                   ((pri_r[0] == pri_r[1]) && (st_time_r[0] >= st_time_r[1]));
  assign b02_nxt = (pri_r[0] > pri_r[2]) ||
                   ((pri_r[0] == pri_r[2]) && (st_time_r[0] >= st_time_r[2]));
  assign b12_nxt = (pri_r[1] > pri_r[2]) ||
                   ((pri_r[1] == pri_r[2]) && (st_time_r[1] >= st_time_r[2]));

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      fresh_r <= fresh_nxt;
      b01_r   <= b01_nxt;
      b02_r   <= b02_nxt;
      b12_r   <= b12_nxt;
    end
  end

  assign win[0] = fresh_r[0] && (!fresh_r[1] || b01_r) && (!fresh_r[2] || b02_r);
  assign win[1] = fresh_r[1] && (!fresh_r[0] || !b01_r) && (!fresh_r[2] || b12_r);
  assign win[2] = fresh_r[2] && (!fresh_r[0] || !b02_r) && (!fresh_r[1] || !b12_r);

  always_comb begin
    sel_code = NO_SRC;
    for (int i = NUM_SRC - 1; i >= 0; i--) begin
      if (win[i]) begin
        sel_code = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= NO_SRC;
    end else if (cmd.load) begin
      active_r <= sel_code;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_sel_r <= sel_code;
      out_chg_r <= (sel_code != active_r);
      if (sel_code == NO_SRC) begin
        out_lin_r <= '0;
        out_ang_r <= '0;
      end else begin
        out_lin_r <= st_lin_r[sel_code];
        out_ang_r <= st_ang_r[sel_code];
      end
    end
  end

  assign out_linear_velocity_out  = out_lin_r;
  assign out_angular_velocity_out = out_ang_r;
  assign out_selected_source      = out_sel_r;
  assign out_source_changed       = out_chg_r;

endmodule
`default_nettype wire

FILE: src/priority_command_arbiter.sv
// Top level of the priority command arbiter.
//
// Input channel (in_valid/in_ready): one item per transfer. Mode 0 is a
// velocity command from source 0..2 (index 3 is dropped); it is clamped to
// the configured limits and stored with its time, or a non-finite command
// drops the source. Mode 1 is a publish tick.
// Output channel (out_valid/out_ready): one result per tick, none per command:
// selected velocities (zero when no source is fresh), source code (3 = none)
// and a flag for a change of source since the previous tick.
// Sequencing: a command passes through capture and store; a tick through
// capture, the freshness/ranking register and selection, which loads the
// output register. No new item is taken until the last one is through.
// The output register holds the result while the receiver stalls; the next
// item is taken meanwhile, and a following tick waits in its selection step
// until the output register is free.
// Reset (rst_n low, synchronous) restores the default registers, clears all
// held commands and sets the active source to none. The user must write
// configuration (cfg_we/cfg_index/cfg_data) only while idle; not enforced.
`default_nettype none
module priority_command_arbiter
  import pca_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_mode,
  input  wire logic [IDX_W-1:0]         in_source_index,
  input  wire logic signed [VEL_W-1:0]  in_linear_velocity_in,
  input  wire logic signed [VEL_W-1:0]  in_angular_velocity_in,
  input  wire logic                     in_not_finite,
  input  wire logic [TIME_W-1:0]        in_current_time,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [VEL_W-1:0]       out_linear_velocity_out,
  output logic signed [VEL_W-1:0]       out_angular_velocity_out,
  output logic [IDX_W-1:0]              out_selected_source,
  output logic                          out_source_changed
);

  pca_cmd_t cmd;
  pca_sts_t sts;

  pca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pca_dp u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .sts                      (sts),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_mode                  (in_mode),
    .in_source_index          (in_source_index),
    .in_linear_velocity_in    (in_linear_velocity_in),
    .in_angular_velocity_in   (in_angular_velocity_in),
    .in_not_finite            (in_not_finite),
    .in_current_time          (in_current_time),
    .out_linear_velocity_out  (out_linear_velocity_out),
    .out_angular_velocity_out (out_angular_velocity_out),
    .out_selected_source      (out_selected_source),
    .out_source_changed       (out_source_changed)
  );

endmodule
`default_nettype wire

FILE: src/pca_checker.sv
// Port-level checks for the priority command arbiter, bound to the top level.
`default_nettype none
module pca_checker
  import pca_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    in_mode,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [VEL_W-1:0] out_linear_velocity_out,
  input wire logic signed [VEL_W-1:0] out_angular_velocity_out,
  input wire logic [IDX_W-1:0]        out_selected_source,
  input wire logic                    out_source_changed
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_selected_source) &&
      $stable(out_linear_velocity_out) && $stable(out_angular_velocity_out) &&
      $stable(out_source_changed))
    else $error("stalled result changed");

  // no source selected means zero velocity
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_selected_source == NO_SRC |->
      out_linear_velocity_out == '0 && out_angular_velocity_out == '0)
    else $error("nonzero velocity without a source");

  // a command produces no result
  a_cmd_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_CMD && !out_valid |=>
      !out_valid ##1 !out_valid)
    else $error("result after a command");

  // an accepted item keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

endmodule

bind priority_command_arbiter pca_checker u_pca_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .in_valid                 (in_valid),
  .in_ready                 (in_ready),
  .in_mode                  (in_mode),
  .out_valid                (out_valid),
  .out_ready                (out_ready),
  .out_linear_velocity_out  (out_linear_velocity_out),
  .out_angular_velocity_out (out_angular_velocity_out),
  .out_selected_source      (out_selected_source),
  .out_source_changed       (out_source_changed)
);
`default_nettype wire

FILE: test/selection_checker.sv
// Checker for the priority command arbiter: tracks commands and predicts each tick's selection.
`timescale 1ns / 100ps
module selection_checker
  import pca_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_mode,
  input  logic [IDX_W-1:0]        in_source_index,
  input  logic signed [VEL_W-1:0] in_linear_velocity_in,
  input  logic signed [VEL_W-1:0] in_angular_velocity_in,
  input  logic                    in_not_finite,
  input  logic [TIME_W-1:0]       in_current_time,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [VEL_W-1:0] out_linear_velocity_out,
  input  logic signed [VEL_W-1:0] out_angular_velocity_out,
  input  logic [IDX_W-1:0]        out_selected_source,
  input  logic                    out_source_changed,
  output int                      mismatch_count,
  output int                      selections_pending,
  output int                      selections_checked
);

  typedef struct packed {
    logic signed [VEL_W-1:0] lin;
    logic signed [VEL_W-1:0] ang;
    logic [IDX_W-1:0]        src;
    logic                    changed;
  } selection_t;

  logic [LIM_W-1:0]        lin_limit;
  logic [LIM_W-1:0]        ang_limit;
  logic signed [PRI_W-1:0] prio [NUM_SRC];
  logic [TMO_W-1:0]        timeout [NUM_SRC];

  logic signed [VEL_W-1:0] held_lin [NUM_SRC];
  logic signed [VEL_W-1:0] held_ang [NUM_SRC];
  logic [TIME_W-1:0]       held_time [NUM_SRC];
  logic                    held [NUM_SRC];
  logic [IDX_W-1:0]        last_source;

  selection_t expected_selections [$];

  initial begin
    mismatch_count = 0;
    selections_pending = 0;
    selections_checked = 0;
  end

  task automatic restore_defaults();
    int s;
    lin_limit = LIN_LIMIT_RST;
    ang_limit = ANG_LIMIT_RST;
    prio[0] = PRI0_RST;
    prio[1] = PRI1_RST;
    prio[2] = PRI2_RST;
    for (s = 0; s < NUM_SRC; s++) begin
      timeout[s] = TMO_RST;
      held_lin[s] = '0;
      held_ang[s] = '0;
      held_time[s] = '0;
      held[s] = 1'b0;
    end
    last_source = NO_SRC;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LIN_LIMIT: lin_limit = data[LIM_W-1:0];
      REG_ANG_LIMIT: ang_limit = data[LIM_W-1:0];
      REG_PRI0:      prio[0] = data;
      REG_PRI1:      prio[1] = data;
      REG_PRI2:      prio[2] = data;
      REG_TMO0:      timeout[0] = data;
      REG_TMO1:      timeout[1] = data;
      REG_TMO2:      timeout[2] = data;
      default: ;
    endcase
  endtask

  function automatic logic signed [VEL_W-1:0] clamp_velocity(
      input logic signed [VEL_W-1:0] v, input logic [LIM_W-1:0] lim);
    int bound;
    int x;
    bound = int'(lim);
    x = int'(v);
    if (x > bound) x = bound;
    else if (x < -bound) x = -bound;
    return x[VEL_W-1:0];
  endfunction

  // Store or drop a command, or pick the best-ranked fresh source on a tick.
  task automatic apply_item(input logic mode, input logic [IDX_W-1:0] idx,
                            input logic signed [VEL_W-1:0] lin,
                            input logic signed [VEL_W-1:0] ang,
                            input logic nf, input logic [TIME_W-1:0] now);
    int s;
    int best;
    selection_t sel;
    if (mode == MODE_CMD) begin
      if (idx != NO_SRC) begin
        if (nf) begin
          held[idx] = 1'b0;
        end else begin
          held_lin[idx] = clamp_velocity(lin, lin_limit);
          held_ang[idx] = clamp_velocity(ang, ang_limit);
          held_time[idx] = now;
          held[idx] = 1'b1;
        end
      end
    end else begin
      best = -1;
      for (s = 0; s < NUM_SRC; s++) begin
        // skip stale sources and those stamped in the future
        if (held[s] && held_time[s] <= now &&
            now - held_time[s] <= TIME_W'(timeout[s])) begin
          if (best < 0 || prio[s] > prio[best] ||
              (prio[s] == prio[best] && held_time[s] > held_time[best]))
            best = s;
        end
      end
      if (best >= 0) begin
        sel.lin = held_lin[best];
        sel.ang = held_ang[best];
        sel.src = best[IDX_W-1:0];
      end else begin
        sel.lin = '0;
        sel.ang = '0;
        sel.src = NO_SRC;
      end
      sel.changed = (sel.src != last_source);
      last_source = sel.src;
      expected_selections.insert(expected_selections.size(), sel);
    end
  endtask

  task automatic check_field(input string name, input logic [VEL_W-1:0] e,
                             input logic [VEL_W-1:0] a);
    if (a !== e) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name,
               $signed(e), $signed(a));
      mismatch_count++;
    end
  endtask

  task automatic compare_result();
    selection_t e;
    if (expected_selections.size() == 0) begin
      $display("%0t ns: result with nothing expected, source %0d lin %0d ang %0d",
               $time, out_selected_source, out_linear_velocity_out,
               out_angular_velocity_out);
      mismatch_count++;
    end else begin
      e = expected_selections.pop_front();
      selections_checked++;
      check_field("linear velocity", e.lin, out_linear_velocity_out);
      check_field("angular velocity", e.ang, out_angular_velocity_out);
      check_field("selected source", VEL_W'(e.src), VEL_W'(out_selected_source));
      check_field("source changed", VEL_W'(e.changed), VEL_W'(out_source_changed));
    end
  endtask

  // Results are older than any item accepted at the same edge: compare first.
  always @(posedge clk) begin
    if (!rst_n) begin
      restore_defaults();
      expected_selections.delete();
    end else begin
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready)
        apply_item(in_mode, in_source_index, in_linear_velocity_in,
                   in_angular_velocity_in, in_not_finite, in_current_time);
      if (cfg_we) write_register(cfg_index, cfg_data);
    end
    selections_pending = expected_selections.size();
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the priority command arbiter: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps
module tb_top;
  import pca_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASE_ITEMS    = 72;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_mode = MODE_CMD;
  logic [IDX_W-1:0]        in_source_index = '0;
  logic signed [VEL_W-1:0] in_linear_velocity_in = '0;
  logic signed [VEL_W-1:0] in_angular_velocity_in = '0;
  logic                    in_not_finite = 1'b0;
  logic [TIME_W-1:0]       in_current_time = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VEL_W-1:0] out_linear_velocity_out;
  logic signed [VEL_W-1:0] out_angular_velocity_out;
  logic [IDX_W-1:0]        out_selected_source;
  logic                    out_source_changed;

  int mismatch_count;
  int selections_pending;
  int selections_checked;

  int tx_idle_pct = 10;
  int rx_idle_pct = 10;
  bit hold_req = 1'b0;
  int stall_cycles = 0;
  int commands_sent = 0;
  int ticks_sent = 0;
  int settings_used = 1;

  // Mirror of the settings, used only to shape the stimulus
  int lin_lim_now = int'(LIN_LIMIT_RST);
  int ang_lim_now = int'(ANG_LIMIT_RST);
  int max_tmo = int'(TMO_RST);
  logic [TIME_W-1:0] now_ms = '0;

  priority_command_arbiter u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_mode                  (in_mode),
    .in_source_index          (in_source_index),
    .in_linear_velocity_in    (in_linear_velocity_in),
    .in_angular_velocity_in   (in_angular_velocity_in),
    .in_not_finite            (in_not_finite),
    .in_current_time          (in_current_time),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_linear_velocity_out  (out_linear_velocity_out),
    .out_angular_velocity_out (out_angular_velocity_out),
    .out_selected_source      (out_selected_source),
    .out_source_changed       (out_source_changed)
  );

  selection_checker u_checker (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_mode                  (in_mode),
    .in_source_index          (in_source_index),
    .in_linear_velocity_in    (in_linear_velocity_in),
    .in_angular_velocity_in   (in_angular_velocity_in),
    .in_not_finite            (in_not_finite),
    .in_current_time          (in_current_time),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_linear_velocity_out  (out_linear_velocity_out),
    .out_angular_velocity_out (out_angular_velocity_out),
    .out_selected_source      (out_selected_source),
    .out_source_changed       (out_source_changed),
    .mismatch_count           (mismatch_count),
    .selections_pending       (selections_pending),
    .selections_checked       (selections_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d selections outstanding",
               $time, stall_cycles, selections_pending);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer(input logic mode, input logic [IDX_W-1:0] idx,
                       input logic [VEL_W-1:0] lin, input logic [VEL_W-1:0] ang,
                       input logic nf, input logic [TIME_W-1:0] t);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_source_index <= idx;
    in_linear_velocity_in <= lin;
    in_angular_velocity_in <= ang;
    in_not_finite <= nf;
    in_current_time <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (mode == MODE_TICK) ticks_sent++;
    else commands_sent++;
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
  endtask

  // Wait until every selection is out, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (selections_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [15:0] lin_l, input logic [15:0] ang_l,
                               input logic [15:0] p0, input logic [15:0] p1,
                               input logic [15:0] p2, input logic [15:0] t0,
                               input logic [15:0] t1, input logic [15:0] t2);
    write_reg(REG_LIN_LIMIT, lin_l);
    write_reg(REG_ANG_LIMIT, ang_l);
    write_reg(REG_PRI0, p0);
    write_reg(REG_PRI1, p1);
    write_reg(REG_PRI2, p2);
    write_reg(REG_TMO0, t0);
    write_reg(REG_TMO1, t1);
    write_reg(REG_TMO2, t2);
    cfg_we <= 1'b0;
    lin_lim_now = int'(lin_l[LIM_W-1:0]);
    ang_lim_now = int'(ang_l[LIM_W-1:0]);
    max_tmo = int'(t0);
    if (int'(t1) > max_tmo) max_tmo = int'(t1);
    if (int'(t2) > max_tmo) max_tmo = int'(t2);
    settings_used++;
  endtask

  function automatic logic [VEL_W-1:0] pick_velocity(input int lim);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return VEL_W'(lim);
      3: return VEL_W'(-lim);
      4: return VEL_W'(lim + 1);
      5: return VEL_W'(-lim - 1);
      6, 7: return VEL_W'(int'($urandom_range(0, 2 * lim)) - lim);
      default: return VEL_W'($urandom);
    endcase
  endfunction

  // Move time mostly forward in steps around the timeouts, sometimes back.
  task automatic advance_time();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) ;
    else if (pick < 12) now_ms += TIME_W'($urandom_range(1, 60));
    else if (pick < 16) now_ms += TIME_W'($urandom_range(1, 300));
    else if (pick < 17) now_ms += TIME_W'($urandom_range(0, 3 * max_tmo));
    else if (pick < 18) now_ms -= TIME_W'($urandom_range(1, 500));
    else now_ms += TIME_W'($urandom_range(max_tmo > 2 ? max_tmo - 2 : 0, max_tmo + 2));
  endtask

  task automatic random_items(input int count, input int hold_at);
    int k;
    logic [IDX_W-1:0] idx;
    for (k = 0; k < count; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      sender_gap();
      advance_time();
      if ($urandom_range(0, 99) < 40) begin
        offer(MODE_TICK, IDX_W'($urandom), VEL_W'($urandom), VEL_W'($urandom),
              1'($urandom), now_ms);
      end else begin
        idx = ($urandom_range(0, 19) == 0) ? NO_SRC : IDX_W'($urandom_range(0, 2));
        offer(MODE_CMD, idx, pick_velocity(lin_lim_now), pick_velocity(ang_lim_now),
              $urandom_range(0, 11) == 0, now_ms);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset settings
    offer(MODE_TICK, 0, 0, 0, 0, 48'd1000);
    offer(MODE_CMD, 0, 16'h7fff, 16'h8000, 0, 48'd1000);
    offer(MODE_CMD, 1, 16'h8000, 16'h7fff, 0, 48'd1000);
    offer(MODE_CMD, 2, 16'h1234, -16'sd5, 0, 48'd1000);
    offer(MODE_CMD, NO_SRC, 16'd100, 16'd100, 0, 48'd1000);
    offer(MODE_TICK, 1, 16'hffff, 16'hffff, 1, 48'd1000);
    offer(MODE_TICK, 2, 0, 0, 0, 48'd1250);
    offer(MODE_TICK, 0, 0, 0, 0, 48'd1251);
    offer(MODE_CMD, 1, -16'sd100, 16'd200, 0, 48'd1300);
    offer(MODE_CMD, 0, 16'd7, 16'd7, 1, 48'd1300);
    offer(MODE_TICK, 0, 0, 0, 0, 48'd1300);
    offer(MODE_CMD, 0, 16'd5, 16'd6, 0, 48'd1400);
    offer(MODE_TICK, 0, 0, 0, 0, 48'd1399);
    offer(MODE_TICK, 0, 0, 0, 0, 48'd1400);
    offer(MODE_CMD, 2, 16'hffff, 16'd1, 0, {TIME_W{1'b1}});
    offer(MODE_TICK, 3, 0, 0, 0, {TIME_W{1'b1}});
    offer(MODE_TICK, 0, 0, 0, 0, 48'd0);
    offer(MODE_CMD, 2, 0, 0, 1, 48'd0);
    offer(MODE_CMD, NO_SRC, 0, 0, 1, 48'd0);
    offer(MODE_TICK, 0, 0, 0, 0, 48'd0);

    // Extreme settings; limit data with bit 15 set must be masked
    drain();
    load_settings(16'h7fff, 16'hffff, 16'h7fff, 16'h8000, 16'h0000,
                  16'hffff, 16'd1, 16'hffff);
    now_ms = TIME_W'({$urandom, $urandom});
    random_items(PHASE_ITEMS, -1);

    // Zero limits and zero timeouts with tied priorities
    drain();
    load_settings(16'd0, 16'd0, 16'd5, 16'd5, 16'd5, 16'd0, 16'd0, 16'd0);
    now_ms = TIME_W'({$urandom, $urandom});
    random_items(PHASE_ITEMS, -1);

    // Smallest limits, lowest tied priorities; no idling on either side
    drain();
    load_settings(16'd1, 16'd1, 16'h8000, 16'h8000, 16'h8000,
                  16'd1, 16'hffff, 16'd250);
    now_ms = 48'hffff_ffff_ff00;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_items(PHASE_ITEMS, -1);
    tx_idle_pct = 10;
    rx_idle_pct = 10;

    // Near-tied random priorities, short timeouts
    drain();
    load_settings(CFG_DATA_W'($urandom_range(1, 32767)),
                  CFG_DATA_W'($urandom_range(1, 32767)),
                  CFG_DATA_W'($urandom_range(0, 4) - 2),
                  CFG_DATA_W'($urandom_range(0, 4) - 2),
                  CFG_DATA_W'($urandom_range(0, 4) - 2),
                  CFG_DATA_W'($urandom_range(1, 400)),
                  CFG_DATA_W'($urandom_range(1, 400)),
                  CFG_DATA_W'($urandom_range(1, 400)));
    now_ms = TIME_W'({$urandom, $urandom});
    random_items(PHASE_ITEMS, -1);

    // Fully random settings; receiver holds off while the sender keeps offering
    drain();
    load_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom_range(1, 65535)),
                  CFG_DATA_W'($urandom_range(1, 65535)),
                  CFG_DATA_W'($urandom_range(1, 65535)));
    now_ms = TIME_W'({$urandom, $urandom});
    tx_idle_pct = 0;
    random_items(40, 10);
    tx_idle_pct = 10;
    random_items(PHASE_ITEMS - 40, -1);

    drain();
    load_settings(CFG_DATA_W'($urandom_range(1, 32767)),
                  CFG_DATA_W'($urandom_range(1, 32767)),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom_range(1, 1000)),
                  CFG_DATA_W'($urandom_range(1, 65535)),
                  CFG_DATA_W'($urandom_range(1, 1000)));
    now_ms = TIME_W'({$urandom, $urandom});
    random_items(PHASE_ITEMS, -1);

    drain();
    repeat (10) @(negedge clk);

    $display("Sent %0d commands and %0d ticks across %0d register settings;",
             commands_sent, ticks_sent, settings_used);
    $display("checked %0d selections, %0d mismatches, %0d left outstanding.",
             selections_checked, mismatch_count, selections_pending);
    if (mismatch_count == 0 && selections_pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
src/pca_pkg.sv
src/pca_ctrl.sv
src/pca_dp.sv
src/priority_command_arbiter.sv
src/pca_checker.sv
test/selection_checker.sv
test/tb_top.sv
